@@ rtl/core/gfg_pkg.sv @@
// ----------------------------------------------------------------------------
// gfg_pkg
// Shared widths, register codes and the item record of the grid gradient.
// ----------------------------------------------------------------------------
package gfg_pkg;

   localparam int IDX_W          = 10;
   localparam int SMP_W          = 16;
   localparam int INV_W          = 16;
   localparam int FLD_W          = 32;
   localparam int PROD_W         = 34;
   localparam int MAX_POINTS_DEF = 1024;
   localparam int QUEUE_DEPTH    = 4;
   localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [IDX_W-1:0] LAST_RESET = 10'd100;
   localparam logic [INV_W-1:0] INV_RESET  = 16'd8533;

   typedef enum logic [0:0] {
      REG_GRID_LAST   = 1'b0,
      REG_INV_SPACING = 1'b1
   } reg_sel_type;

   typedef enum logic [1:0] {
      JOB_UP   = 2'd0,
      JOB_LAST = 2'd1,
      JOB_DONE = 2'd2
   } job_type;

   typedef logic signed [SMP_W-1:0] sample_type;

   // one accepted sample at (k, m) and every neighbor its results need
   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             job_up;     // result (k-1, m)
      logic             job_last;   // result (n, m-1)
      logic             job_done;   // result (n, n)
      logic             top_row;
      logic             first_col;
      logic             second_col;
      logic             last_col;
      sample_type       above;      // (k-2, m)
      sample_type       left;       // (k-1, m-1)
      sample_type       center;     // (k-1, m)
      sample_type       right;      // (k-1, m+1)
      sample_type       cur;        // (k, m)
      sample_type       cur_p1;     // (k, m-1)
      sample_type       cur_p2;     // (k, m-2)
   } gfg_item_type;

endpackage

@@ rtl/core/gfg_req_if.sv @@
// ----------------------------------------------------------------------------
// gfg_req_if
// Sample channel: one potential sample per beat.
// ----------------------------------------------------------------------------
interface gfg_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [gfg_pkg::SMP_W-1:0]    potential;

   modport source (output valid, output potential, input ready);
   modport sink   (input valid, input potential, output ready);
endinterface

@@ rtl/core/gfg_rsp_if.sv @@
// ----------------------------------------------------------------------------
// gfg_rsp_if
// Result channel: one field vector per beat.
// ----------------------------------------------------------------------------
interface gfg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic        [gfg_pkg::IDX_W-1:0]    row_index;
   logic        [gfg_pkg::IDX_W-1:0]    col_index;
   logic signed [gfg_pkg::FLD_W-1:0]    field_x;
   logic signed [gfg_pkg::FLD_W-1:0]    field_y;
   logic                                grid_done;

   modport source (output valid, output row_index, output col_index, output field_x,
                   output field_y, output grid_done, input ready);
   modport sink   (input valid, input row_index, input col_index, input field_x,
                   input field_y, input grid_done, output ready);
endinterface

@@ rtl/core/gfg_front.sv @@
// ----------------------------------------------------------------------------
// gfg_front
// Accepts samples, tracks row/column, keeps the three-row ring and gathers
// the neighbor samples of each sample into one queue record.
// ----------------------------------------------------------------------------
module gfg_front #(
   parameter int MAX_POINTS = gfg_pkg::MAX_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic [gfg_pkg::IDX_W-1:0]     last_n,
   gfg_req_if.sink                       req_bus,
   input  logic [gfg_pkg::CNT_W-1:0]     queue_count,
   output logic                          push,
   output gfg_pkg::gfg_item_type         push_item
);

   localparam int COL_W      = $clog2(MAX_POINTS);
   localparam int RING_DEPTH = 3 * MAX_POINTS;
   localparam int ADDR_W     = $clog2(RING_DEPTH);

   function automatic logic [ADDR_W-1:0] ring_addr(input logic [1:0] slot,
                                                   input logic [gfg_pkg::IDX_W-1:0] col);
      logic [ADDR_W-1:0] base;
      case (slot)
         2'd1: begin
            base = ADDR_W'(MAX_POINTS);
         end
         2'd2: begin
            base = ADDR_W'(2 * MAX_POINTS);
         end
         default: begin
            base = '0;
         end
      endcase
      return base + ADDR_W'(COL_W'(col));
   endfunction

   logic [gfg_pkg::SMP_W-1:0] ring_mem [0:RING_DEPTH-1];

   logic [gfg_pkg::IDX_W-1:0] row_ff, row_in, col_ff, col_in;
   logic [1:0]                slot_ff, slot_in;
   logic [gfg_pkg::IDX_W-1:0] row_now, col_now, rd_col;
   logic [1:0]                slot_now, slot_up, slot_dn;
   logic                      wrapped, accept;

   gfg_pkg::sample_type       p1_ff, p2_ff, head_ff;
   gfg_pkg::sample_type       above_rd_ff, right_rd_ff;
   gfg_pkg::sample_type       wc_ff, wr_ff, s1_head_ff;
   gfg_pkg::sample_type       center;
   logic                      s1_valid_ff;
   gfg_pkg::gfg_item_type     s1_ff, s1_in;

   assign wrapped  = (row_ff > last_n) || (col_ff > last_n);
   assign row_now  = wrapped ? '0 : row_ff;
   assign col_now  = wrapped ? '0 : col_ff;
   assign slot_now = wrapped ? 2'd0 : slot_ff;
   assign slot_up  = (slot_now == 2'd2) ? 2'd0 : slot_now + 2'd1;
   assign slot_dn  = (slot_now == 2'd0) ? 2'd2 : slot_now - 2'd1;
   assign rd_col   = (col_now == last_n) ? col_now : col_now + gfg_pkg::IDX_W'(1);

   assign req_bus.ready = ({1'b0, queue_count} + {{gfg_pkg::CNT_W{1'b0}}, s1_valid_ff})
                          < (gfg_pkg::CNT_W + 1)'(gfg_pkg::QUEUE_DEPTH);
   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      slot_in = slot_ff;
      if (restart) begin
         row_in  = '0;
         col_in  = '0;
         slot_in = 2'd0;
      end else if (accept) begin
         if (col_now == last_n) begin
            col_in = '0;
            if (row_now == last_n) begin
               row_in  = '0;
               slot_in = 2'd0;
            end else begin
               row_in  = row_now + gfg_pkg::IDX_W'(1);
               slot_in = slot_up;
            end
         end else begin
            col_in  = col_now + gfg_pkg::IDX_W'(1);
            row_in  = row_now;
            slot_in = slot_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         slot_ff     <= 2'd0;
         s1_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         slot_ff     <= slot_in;
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ring_mem[ring_addr(slot_now, col_now)] <= req_bus.potential;
         above_rd_ff <= ring_mem[ring_addr(slot_up, col_now)];
         right_rd_ff <= ring_mem[ring_addr(slot_dn, rd_col)];
      end
   end

   always_comb begin
      s1_in            = s1_ff;
      s1_in.row        = row_now;
      s1_in.col        = col_now;
      s1_in.job_up     = (row_now != '0);
      s1_in.job_last   = (row_now == last_n) && (col_now != '0);
      s1_in.job_done   = (row_now == last_n) && (col_now == last_n);
      s1_in.top_row    = (row_now == gfg_pkg::IDX_W'(1));
      s1_in.first_col  = (col_now == '0);
      s1_in.second_col = (col_now == gfg_pkg::IDX_W'(1));
      s1_in.last_col   = (col_now == last_n);
      s1_in.cur        = req_bus.potential;
      s1_in.cur_p1     = p1_ff;
      s1_in.cur_p2     = p2_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff      <= s1_in;
         p1_ff      <= req_bus.potential;
         p2_ff      <= p1_ff;
         s1_head_ff <= head_ff;
         if (col_now == '0) begin
            head_ff <= req_bus.potential;
         end
      end
   end

   // sliding window over row k-1
   assign center = s1_ff.first_col ? s1_head_ff : wr_ff;

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         wc_ff <= center;
         wr_ff <= right_rd_ff;
      end
   end

   always_comb begin
      push_item        = s1_ff;
      push_item.above  = above_rd_ff;
      push_item.left   = wc_ff;
      push_item.center = center;
      push_item.right  = right_rd_ff;
   end

   assign push = s1_valid_ff && (s1_ff.job_up || s1_ff.job_last || s1_ff.job_done);

`ifndef SYNTHESIS
   a_grid_wraps: assert property (@(posedge clock) disable iff (reset)
      accept && (row_now == last_n) && (col_now == last_n) |=> (row_ff == '0) && (col_ff == '0))
      else $error("counters did not return to origin after final point");
`endif

endmodule

@@ rtl/core/gfg_queue.sv @@
// ----------------------------------------------------------------------------
// gfg_queue
// Short FIFO of item records between front and back.
// ----------------------------------------------------------------------------
module gfg_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  gfg_pkg::gfg_item_type         push_item,
   input  logic                          pop,
   output logic                          head_valid,
   output gfg_pkg::gfg_item_type         head_item,
   output logic [gfg_pkg::CNT_W-1:0]     count
);

   localparam int PTR_W = $clog2(gfg_pkg::QUEUE_DEPTH);

   gfg_pkg::gfg_item_type     entry_ff [0:gfg_pkg::QUEUE_DEPTH-1];
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [gfg_pkg::CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + gfg_pkg::CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - gfg_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff < gfg_pkg::CNT_W'(gfg_pkg::QUEUE_DEPTH))
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue underflow");
`endif

endmodule

@@ rtl/core/gfg_back.sv @@
// ----------------------------------------------------------------------------
// gfg_back
// Expands each record into its results: difference, scale, round and
// saturate, then the result register.
// ----------------------------------------------------------------------------
module gfg_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [gfg_pkg::INV_W-1:0]     inv_spacing,
   input  logic                          head_valid,
   input  gfg_pkg::gfg_item_type         head_item,
   output logic                          pop,
   gfg_rsp_if.source                     rsp_bus
);

   localparam int IDX_W  = gfg_pkg::IDX_W;
   localparam int SMP_W  = gfg_pkg::SMP_W;
   localparam int PROD_W = gfg_pkg::PROD_W;
   localparam int FLD_W  = gfg_pkg::FLD_W;

   typedef struct packed {
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [SMP_W:0]   diff_x;
      logic signed [SMP_W:0]   diff_y;
      logic                    halve_x;
      logic                    halve_y;
      logic                    done;
   } diff_type;

   typedef struct packed {
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [PROD_W-1:0] prod_x;
      logic signed [PROD_W-1:0] prod_y;
      logic                    halve_x;
      logic                    halve_y;
      logic                    done;
   } prod_type;

   function automatic logic [FLD_W-1:0] scale_sat(input logic signed [PROD_W-1:0] p,
                                                  input logic halve);
      logic              neg;
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] rnd;
      logic [FLD_W-1:0]  res;
      neg = p[PROD_W-1];
      mag = neg ? PROD_W'(-p) : PROD_W'(p);
      rnd = halve ? ((mag + PROD_W'(1)) >> 1) : mag;
      if (neg) begin
         if (rnd > PROD_W'(64'h8000_0000)) begin
            res = 32'h8000_0000;
         end else begin
            res = FLD_W'(PROD_W'(0) - rnd);
         end
      end else begin
         if (rnd > PROD_W'(64'h7FFF_FFFF)) begin
            res = 32'h7FFF_FFFF;
         end else begin
            res = FLD_W'(rnd);
         end
      end
      return res;
   endfunction

   logic [2:0]           jobs, pend, sel_mask, done_ff, done_in;
   gfg_pkg::job_type     job;
   logic                 issue, o_en, m_en, d_en;
   gfg_pkg::sample_type  ax, bx, ay, by;
   logic                 hx, hy;
   diff_type             d_ff, d_in;
   prod_type             m_ff, m_in;
   logic                 d_valid_ff, m_valid_ff, o_valid_ff;
   logic [IDX_W-1:0]     o_row_ff, o_col_ff;
   logic [FLD_W-1:0]     o_fx_ff, o_fy_ff;
   logic                 o_done_ff;

   assign o_en = !o_valid_ff || rsp_bus.ready;
   assign m_en = !m_valid_ff || o_en;
   assign d_en = !d_valid_ff || m_en;

   assign jobs = {head_item.job_done, head_item.job_last, head_item.job_up};
   assign pend = jobs & ~done_ff;

   always_comb begin
      if (pend[0]) begin
         job      = gfg_pkg::JOB_UP;
         sel_mask = 3'b001;
      end else if (pend[1]) begin
         job      = gfg_pkg::JOB_LAST;
         sel_mask = 3'b010;
      end else begin
         job      = gfg_pkg::JOB_DONE;
         sel_mask = 3'b100;
      end
   end

   assign issue = head_valid && d_en;
   assign pop   = issue && ((pend & ~sel_mask) == 3'b000);

   always_comb begin
      done_in = done_ff;
      if (pop) begin
         done_in = 3'b000;
      end else if (issue) begin
         done_in = done_ff | sel_mask;
      end
   end

   always_comb begin
      d_in.row  = head_item.row;
      d_in.col  = head_item.col;
      d_in.done = 1'b0;
      ax = head_item.center;
      bx = head_item.cur;
      ay = head_item.cur_p1;
      by = head_item.cur;
      hx = 1'b0;
      hy = 1'b0;
      case (job)
         gfg_pkg::JOB_UP: begin
            d_in.row = head_item.row - IDX_W'(1);
            if (!head_item.top_row) begin
               ax = head_item.above;
               hx = 1'b1;
            end
            if (head_item.first_col) begin
               ay = head_item.center;
               by = head_item.right;
            end else if (head_item.last_col) begin
               ay = head_item.left;
               by = head_item.center;
            end else begin
               ay = head_item.left;
               by = head_item.right;
               hy = 1'b1;
            end
         end
         gfg_pkg::JOB_LAST: begin
            d_in.col = head_item.col - IDX_W'(1);
            ax = head_item.left;
            bx = head_item.cur_p1;
            if (!head_item.second_col) begin
               ay = head_item.cur_p2;
               hy = 1'b1;
            end
         end
         gfg_pkg::JOB_DONE: begin
            d_in.done = 1'b1;
         end
         default: begin
            d_in.done = 1'b0;
         end
      endcase
      d_in.diff_x  = {ax[SMP_W-1], ax} - {bx[SMP_W-1], bx};
      d_in.diff_y  = {ay[SMP_W-1], ay} - {by[SMP_W-1], by};
      d_in.halve_x = hx;
      d_in.halve_y = hy;
   end

   always_comb begin
      m_in.row     = d_ff.row;
      m_in.col     = d_ff.col;
      m_in.prod_x  = d_ff.diff_x * $signed({1'b0, inv_spacing});
      m_in.prod_y  = d_ff.diff_y * $signed({1'b0, inv_spacing});
      m_in.halve_x = d_ff.halve_x;
      m_in.halve_y = d_ff.halve_y;
      m_in.done    = d_ff.done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff    <= 3'b000;
         d_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         if (d_en) begin
            d_valid_ff <= head_valid;
         end
         if (m_en) begin
            m_valid_ff <= d_valid_ff;
         end
         if (o_en) begin
            o_valid_ff <= m_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         d_ff <= d_in;
      end
      if (m_en && d_valid_ff) begin
         m_ff <= m_in;
      end
      if (o_en && m_valid_ff) begin
         o_row_ff  <= m_ff.row;
         o_col_ff  <= m_ff.col;
         o_fx_ff   <= scale_sat(m_ff.prod_x, m_ff.halve_x);
         o_fy_ff   <= scale_sat(m_ff.prod_y, m_ff.halve_y);
         o_done_ff <= m_ff.done;
      end
   end

   assign rsp_bus.valid     = o_valid_ff;
   assign rsp_bus.row_index = o_row_ff;
   assign rsp_bus.col_index = o_col_ff;
   assign rsp_bus.field_x   = o_fx_ff;
   assign rsp_bus.field_y   = o_fy_ff;
   assign rsp_bus.grid_done = o_done_ff;

`ifndef SYNTHESIS
   a_done_on_diagonal: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff && o_done_ff |-> o_row_ff == o_col_ff)
      else $error("grid_done off the final point");
`endif

endmodule

@@ rtl/core/grid_field_gradient.sv @@
// ----------------------------------------------------------------------------
// grid_field_gradient
// Streaming negative gradient of a potential over a square grid.
// ----------------------------------------------------------------------------
// Samples enter row-major, one per beat, and the block takes one sample per
// clock while the queue has room. Each sample of rows 1..n yields the result
// one row above; samples of the last row also yield the result to their left,
// and the final sample adds point (n, n). Results leave one per clock through
// the result register while the result side is ready, so the single result
// port sets the pace of the last row, whose samples yield more than one result
// each; a four-entry queue between the gathering front and the arithmetic back
// absorbs this and any result-side stall. The ring store needs no clearing
// after reset. Writing grid_last_index starts a new grid at point (0, 0).
module grid_field_gradient #(
   parameter int MAX_POINTS = gfg_pkg::MAX_POINTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   gfg_req_if.sink                            req_bus,
   gfg_rsp_if.source                          rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [gfg_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [gfg_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [gfg_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   localparam int MaxLast = MAX_POINTS - 1;

   logic [gfg_pkg::IDX_W-1:0] last_ff, last_in, last_n;
   logic [gfg_pkg::INV_W-1:0] inv_ff, inv_in;
   gfg_pkg::reg_sel_type      reg_sel;
   logic                      csr_write, restart;
   logic                      push, pop, head_valid;
   gfg_pkg::gfg_item_type     push_item, head_item;
   logic [gfg_pkg::CNT_W-1:0] queue_count;

   assign pready    = 1'b1;
   assign reg_sel   = gfg_pkg::reg_sel_type'(paddr[gfg_pkg::CSR_ADDR_W-1]);
   assign csr_write = psel && penable && pwrite && pready;
   assign restart   = csr_write && (reg_sel == gfg_pkg::REG_GRID_LAST);

   always_comb begin
      last_in = last_ff;
      inv_in  = inv_ff;
      if (restart) begin
         last_in = pwdata[gfg_pkg::IDX_W-1:0];
      end
      if (csr_write && (reg_sel == gfg_pkg::REG_INV_SPACING)) begin
         inv_in = pwdata[gfg_pkg::INV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= gfg_pkg::LAST_RESET;
         inv_ff  <= gfg_pkg::INV_RESET;
      end else begin
         last_ff <= last_in;
         inv_ff  <= inv_in;
      end
   end

   always_comb begin
      case (reg_sel)
         gfg_pkg::REG_GRID_LAST: begin
            prdata = gfg_pkg::CSR_DATA_W'(last_ff);
         end
         gfg_pkg::REG_INV_SPACING: begin
            prdata = gfg_pkg::CSR_DATA_W'(inv_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_comb begin
      if (last_ff == '0) begin
         last_n = gfg_pkg::IDX_W'(1);
      end else if (32'(last_ff) > 32'(MaxLast)) begin
         last_n = gfg_pkg::IDX_W'(MaxLast);
      end else begin
         last_n = last_ff;
      end
   end

   gfg_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .last_n      (last_n),
      .req_bus     (req_bus),
      .queue_count (queue_count),
      .push        (push),
      .push_item   (push_item)
   );

   gfg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .count      (queue_count)
   );

   gfg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .inv_spacing (inv_ff),
      .head_valid  (head_valid),
      .head_item   (head_item),
      .pop         (pop),
      .rsp_bus     (rsp_bus)
   );

endmodule

@@ verif/gfg_field_checker.sv @@
// ----------------------------------------------------------------------------
// gfg_field_checker
// Watches the sample, result and register ports of grid_field_gradient, works
// out the field vectors each accepted sample releases and compares every
// result beat, in order, against them. Register reads are checked as well.
// ----------------------------------------------------------------------------
module gfg_field_checker (
   input  logic                             clock,
   input  logic                             reset,
   gfg_req_if                               req_mon,
   gfg_rsp_if                               rsp_mon,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [gfg_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [gfg_pkg::CSR_DATA_W-1:0]   pwdata,
   input  logic [gfg_pkg::CSR_DATA_W-1:0]   prdata,
   input  logic                             pready,
   output int                               mismatches,
   output int                               points_due,
   output int                               points_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     MAXP      = gfg_pkg::MAX_POINTS_DEF;
   localparam int     IDX_W     = gfg_pkg::IDX_W;
   localparam int     FLD_W     = gfg_pkg::FLD_W;
   localparam int     SMP_W     = gfg_pkg::SMP_W;
   localparam int     INV_W     = gfg_pkg::INV_W;
   localparam int     ADDR_W    = gfg_pkg::CSR_ADDR_W;
   localparam int     DATA_W    = gfg_pkg::CSR_DATA_W;
   localparam longint POS_LIMIT = 64'd2147483647;
   localparam longint NEG_LIMIT = 64'd2147483648;

   typedef struct {
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic signed [FLD_W-1:0] fx;
      logic signed [FLD_W-1:0] fy;
      logic                    done;
   } field_point_type;

   field_point_type   field_points_due [$];
   field_point_type   want;
   logic [SMP_W-1:0]  potential_ring [0:3*MAXP-1];
   logic [IDX_W-1:0]  grid_last_q;
   logic [INV_W-1:0]  inv_spacing_q;
   int                grid_row;
   int                grid_col;
   int                n_eff;
   int                k;
   int                m;
   logic [DATA_W-1:0] reg_word;

   task automatic note_mismatch(input string what);
      if (mismatches < 100) $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
   endtask

   function automatic longint ring_at(input int r, input int c);
      return longint'($signed(potential_ring[(r % 3) * MAXP + (c % MAXP)]));
   endfunction

   // difference times 1/h, halved with round-half-away for central terms
   function automatic logic signed [FLD_W-1:0] field_of(input longint diff, input bit central);
      longint prod;
      longint mag;
      bit     neg;
      prod = diff * longint'(inv_spacing_q);
      neg  = prod < 0;
      mag  = neg ? -prod : prod;
      if (central) mag = (mag + 1) >> 1;
      if (neg) begin
         if (mag > NEG_LIMIT) mag = NEG_LIMIT;
         return FLD_W'(-mag);
      end
      if (mag > POS_LIMIT) mag = POS_LIMIT;
      return FLD_W'(mag);
   endfunction

   task automatic push_point(input int r, input int c, input int n, input bit done);
      field_point_type p;
      longint          dx;
      longint          dy;
      if (r == 0)      dx = ring_at(r, c) - ring_at(r + 1, c);
      else if (r == n) dx = ring_at(r - 1, c) - ring_at(r, c);
      else             dx = ring_at(r - 1, c) - ring_at(r + 1, c);
      if (c == 0)      dy = ring_at(r, c) - ring_at(r, c + 1);
      else if (c == n) dy = ring_at(r, c - 1) - ring_at(r, c);
      else             dy = ring_at(r, c - 1) - ring_at(r, c + 1);
      p.row  = IDX_W'(r);
      p.col  = IDX_W'(c);
      p.fx   = field_of(dx, r != 0 && r != n);
      p.fy   = field_of(dy, c != 0 && c != n);
      p.done = done;
      field_points_due.push_back(p);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         grid_row       = 0;
         grid_col       = 0;
         grid_last_q    = gfg_pkg::LAST_RESET;
         inv_spacing_q  = gfg_pkg::INV_RESET;
         mismatches     = 0;
         points_checked = 0;
         field_points_due.delete();
      end else begin
         if (psel && penable && pready) begin
            if (pwrite) begin
               case (gfg_pkg::reg_sel_type'(paddr[ADDR_W-1:2]))
                  gfg_pkg::REG_GRID_LAST: begin
                     grid_last_q = pwdata[IDX_W-1:0];
                     grid_row    = 0;
                     grid_col    = 0;
                  end
                  gfg_pkg::REG_INV_SPACING: begin
                     inv_spacing_q = pwdata[INV_W-1:0];
                  end
                  default: begin
                  end
               endcase
            end else begin
               case (gfg_pkg::reg_sel_type'(paddr[ADDR_W-1:2]))
                  gfg_pkg::REG_GRID_LAST:   reg_word = DATA_W'(grid_last_q);
                  gfg_pkg::REG_INV_SPACING: reg_word = DATA_W'(inv_spacing_q);
                  default:                  reg_word = '0;
               endcase
               if (prdata !== reg_word)
                  note_mismatch($sformatf("register read at %0d: got %h, want %h",
                                          paddr, prdata, reg_word));
            end
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (field_points_due.size() == 0) begin
               note_mismatch($sformatf("result beat (%0d,%0d) with nothing due",
                                       rsp_mon.row_index, rsp_mon.col_index));
            end else begin
               want = field_points_due.pop_front();
               points_checked++;
               if (rsp_mon.row_index !== want.row)
                  note_mismatch($sformatf("row_index got %0d, want %0d",
                                          rsp_mon.row_index, want.row));
               if (rsp_mon.col_index !== want.col)
                  note_mismatch($sformatf("col_index got %0d, want %0d",
                                          rsp_mon.col_index, want.col));
               if (rsp_mon.field_x !== want.fx)
                  note_mismatch($sformatf("field_x at (%0d,%0d) got %0d, want %0d",
                                          want.row, want.col, rsp_mon.field_x, want.fx));
               if (rsp_mon.field_y !== want.fy)
                  note_mismatch($sformatf("field_y at (%0d,%0d) got %0d, want %0d",
                                          want.row, want.col, rsp_mon.field_y, want.fy));
               if (rsp_mon.grid_done !== want.done)
                  note_mismatch($sformatf("grid_done at (%0d,%0d) got %b, want %b",
                                          want.row, want.col, rsp_mon.grid_done, want.done));
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            n_eff = (grid_last_q < 1) ? 1 : int'(grid_last_q);
            if (n_eff > MAXP - 1) n_eff = MAXP - 1;
            k = grid_row;
            m = grid_col;
            if (k > n_eff || m > n_eff) begin
               k = 0;
               m = 0;
            end
            potential_ring[(k % 3) * MAXP + m] = req_mon.potential;
            if (k >= 1) push_point(k - 1, m, n_eff, 1'b0);
            if (k == n_eff) begin
               if (m >= 1)     push_point(k, m - 1, n_eff, 1'b0);
               if (m == n_eff) push_point(k, m, n_eff, 1'b1);
            end
            if (m == n_eff) begin
               m = 0;
               k = (k == n_eff) ? 0 : k + 1;
            end else begin
               m++;
            end
            grid_row = k;
            grid_col = m;
         end
      end
      points_due = field_points_due.size();
   end

endmodule

@@ verif/tb_grid_field_gradient.sv @@
// ----------------------------------------------------------------------------
// tb_grid_field_gradient
// Streams potential grids of many sizes and spacings into grid_field_gradient
// with random idling on both sides, a long result-side hold-off and full
// drains between grids; gfg_field_checker predicts and checks every beat.
// ----------------------------------------------------------------------------
module tb_grid_field_gradient;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 300_000;
   localparam int PHASE_ITEMS = 70;

   logic                                  clock;
   logic                                  reset;
   logic                                  psel;
   logic                                  penable;
   logic                                  pwrite;
   logic [gfg_pkg::CSR_ADDR_W-1:0]        paddr;
   logic [gfg_pkg::CSR_DATA_W-1:0]        pwdata;
   logic [gfg_pkg::CSR_DATA_W-1:0]        prdata;
   logic                                  pready;

   int mismatch_count;
   int points_due;
   int points_checked;
   int cycle_count    = 0;
   int samples_sent   = 0;
   int grid_setups    = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   bit hold_req       = 1'b0;
   int hold_left      = 0;
   logic signed [gfg_pkg::SMP_W-1:0] last_potential = '0;

   gfg_req_if req_ch ();
   gfg_rsp_if rsp_ch ();

   grid_field_gradient uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch.sink),
      .rsp_bus (rsp_ch.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   gfg_field_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .mismatches     (mismatch_count),
      .points_due     (points_due),
      .points_checked (points_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("timeout after %0d cycles, %0d results still due", cycle_count, points_due);
      $display("== FAIL ==");
      $finish;
   end

   // result side: random stalls, or a long hold-off when requested
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = 80;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic csr_write(input gfg_pkg::reg_sel_type sel,
                            input logic [gfg_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = gfg_pkg::CSR_ADDR_W'({sel, 2'b00});
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic csr_read(input gfg_pkg::reg_sel_type sel);
      @(negedge clock);
      psel    = 1'b1;
      pwrite  = 1'b0;
      penable = 1'b0;
      paddr   = gfg_pkg::CSR_ADDR_W'({sel, 2'b00});
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic send_sample(input logic signed [gfg_pkg::SMP_W-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid     = 1'b1;
      req_ch.potential = value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      samples_sent++;
   endtask

   // sender pause: nothing left due, then past the pipeline latency
   task automatic wait_quiet();
      while (points_due != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   function automatic logic signed [gfg_pkg::SMP_W-1:0] next_potential();
      case ($urandom_range(0, 3))
         0: last_potential = gfg_pkg::SMP_W'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0:       last_potential = 16'sh7FFF;
               1:       last_potential = 16'sh8000;
               2:       last_potential = 16'sh0000;
               default: last_potential = 16'shFFFF;
            endcase
         end
         default: last_potential = last_potential
                                   + gfg_pkg::SMP_W'($urandom_range(0, 400)) - 16'sd200;
      endcase
      return last_potential;
   endfunction

   // new grid: upper data bits are junk the block must ignore
   task automatic setup_grid(input logic [gfg_pkg::IDX_W-1:0] n,
                             input logic [gfg_pkg::INV_W-1:0] inv);
      logic [gfg_pkg::CSR_DATA_W-1:0] word;
      wait_quiet();
      word                     = $urandom;
      word[gfg_pkg::IDX_W-1:0] = n;
      csr_write(gfg_pkg::REG_GRID_LAST, word);
      word                     = $urandom;
      word[gfg_pkg::INV_W-1:0] = inv;
      csr_write(gfg_pkg::REG_INV_SPACING, word);
      csr_read(gfg_pkg::REG_GRID_LAST);
      csr_read(gfg_pkg::REG_INV_SPACING);
      grid_setups++;
   endtask

   task automatic stream(input int count);
      for (int i = 0; i < count; i++) send_sample(next_potential());
      req_ch.valid = 1'b0;
   endtask

   logic signed [gfg_pkg::SMP_W-1:0] corner_2x2 [0:3] =
      '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF};
   logic signed [gfg_pkg::SMP_W-1:0] corner_3x3 [0:8] =
      '{16'sh7FFF, 16'sh8000, 16'sh7FFF,
        16'sh8000, 16'sh0000, 16'shFFFF,
        16'sh7FFF, 16'sh8000, 16'sh0001};

   initial begin
      int n_raw;
      int n_eff;
      int pts;
      int count;
      int start;
      logic [gfg_pkg::INV_W-1:0] inv;

      reset            = 1'b1;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      req_ch.valid     = 1'b0;
      req_ch.potential = '0;
      rsp_ch.ready     = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 9;
      recv_idle_pct = 49;

      // registers at reset, then corner grids: size clamp, saturation, zero spacing
      csr_read(gfg_pkg::REG_GRID_LAST);
      csr_read(gfg_pkg::REG_INV_SPACING);
      setup_grid(10'd0, 16'd256);
      foreach (corner_2x2[i]) send_sample(corner_2x2[i]);
      req_ch.valid = 1'b0;
      setup_grid(10'd2, 16'hFFFF);
      foreach (corner_3x3[i]) send_sample(corner_3x3[i]);
      req_ch.valid = 1'b0;
      setup_grid(10'd1, 16'd0);
      stream(4);

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 49 : 0;
         recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 9 : 0;
         start = samples_sent;
         while (samples_sent - start < PHASE_ITEMS) begin
            n_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 7);
            case ($urandom_range(0, 5))
               0:       inv = '0;
               1:       inv = '1;
               default: inv = gfg_pkg::INV_W'($urandom);
            endcase
            setup_grid(gfg_pkg::IDX_W'(n_raw), inv);
            n_eff = (n_raw < 1) ? 1 : n_raw;
            pts   = (n_eff + 1) * (n_eff + 1);
            case ($urandom_range(0, 7))
               0:       count = $urandom_range(1, pts - 1);
               1:       count = 2 * pts;
               default: count = pts;
            endcase
            stream(count);
         end
      end

      // long result-side hold-off while samples keep coming
      setup_grid(10'd7, gfg_pkg::INV_W'($urandom));
      for (int i = 0; i < 64; i++) begin
         if (i == 16) hold_req = 1'b1;
         send_sample(next_potential());
      end
      req_ch.valid = 1'b0;

      // largest grid: a short stretch of the first row
      setup_grid(10'd1023, gfg_pkg::INV_W'($urandom));
      stream(24);

      wait_quiet();
      repeat (8) @(negedge clock);

      $display("Streamed %0d samples over %0d grid set-ups, sizes 1 to 1023, spacing 0 to 65535.",
               samples_sent, grid_setups);
      $display("Checked %0d field results, with a long result stall and drained pauses.",
               points_checked);
      if (mismatch_count == 0 && points_due == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results still due", mismatch_count, points_due);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/gfg_pkg.sv
rtl/core/gfg_req_if.sv
rtl/core/gfg_rsp_if.sv
rtl/core/gfg_front.sv
rtl/core/gfg_queue.sv
rtl/core/gfg_back.sv
rtl/core/grid_field_gradient.sv
verif/gfg_field_checker.sv
verif/tb_grid_field_gradient.sv
